FILE: rtl/btas_pkg.sv
// ----------------------------------------------------------------------------
// btas_pkg
// Shared widths, types and command/status structs of the best threshold
// accuracy search unit.
// ----------------------------------------------------------------------------
package btas_pkg;

  localparam int unsigned SCORE_BITS = 10;
  localparam int unsigned COUNT_BITS = 20;
  localparam int unsigned BIN_COUNT  = 1 << SCORE_BITS;

  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_FINISH = 2'd2
  } mode_e;

  // one histogram row: both labels of one score code
  typedef struct packed {
    count_t neg;
    count_t pos;
  } bin_t;

  typedef struct packed {
    logic cnt_clr;
    logic samp_start;
    logic samp_write;
    logic drop;
    logic wipe;
    logic sweep_start;
    logic sweep_rd;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_cap;
    logic code_last;
    logic pipe_busy;
  } ctrl_sts_t;

endpackage

FILE: rtl/btas_if.sv
// ----------------------------------------------------------------------------
// btas_if
// Valid/ready channels of the search unit: sample input and result output.
// ----------------------------------------------------------------------------
interface btas_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic                   label;
  btas_pkg::score_t       score;

  modport source (output valid, output mode, output label, output score, input ready);
  modport sink   (input valid, input mode, input label, input score, output ready);
endinterface

interface btas_out_if;
  logic                   valid;
  logic                   ready;
  btas_pkg::score_t       best_threshold;
  btas_pkg::count_t       best_correct;
  btas_pkg::count_t       sample_total;
  logic                   overflowed;

  modport source (output valid, output best_threshold, output best_correct,
                  output sample_total, output overflowed, input ready);
  modport sink   (input valid, input best_threshold, input best_correct,
                  input sample_total, input overflowed, output ready);
endinterface

FILE: rtl/btas_ctrl.sv
// ----------------------------------------------------------------------------
// btas_ctrl
// Controller: accepts transactions, sequences sample updates, clearing
// passes and the threshold sweep, and owns the result valid flag.
// ----------------------------------------------------------------------------
module btas_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_mode_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  btas_pkg::ctrl_sts_t   sts_i,
  output btas_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_ADD,
    ST_SWEEP,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   in_accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_WIPE: begin
        cmd_o.wipe = 1'b1;
        if (sts_i.code_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (btas_pkg::mode_e'(in_mode_i))
            btas_pkg::MODE_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_WIPE;
            end
            btas_pkg::MODE_ADD: begin
              if (sts_i.at_cap) begin
                cmd_o.drop = 1'b1;
              end else begin
                cmd_o.samp_start = 1'b1;
                state_d          = ST_ADD;
              end
            end
            btas_pkg::MODE_FINISH: begin
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        cmd_o.samp_write = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd_o.sweep_rd = 1'b1;
        if (sts_i.code_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy && out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.cnt_clr  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

  a_drop_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.drop |=> (state_q == ST_IDLE))
    else $error("dropped sample started an update");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && sts_i.code_last |=> (state_q == ST_DRAIN))
    else $error("sweep did not end at last code");
`endif

endmodule

FILE: rtl/btas_dp.sv
// ----------------------------------------------------------------------------
// btas_dp
// Datapath: histogram memory, sample totals, sweep pipeline with running
// correct count, best tracking and result register.
// ----------------------------------------------------------------------------
module btas_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btas_pkg::ctrl_cmd_t   cmd_i,
  output btas_pkg::ctrl_sts_t   sts_o,
  input  logic                  in_label_i,
  input  btas_pkg::score_t      in_score_i,
  output btas_pkg::score_t      best_threshold_o,
  output btas_pkg::count_t      best_correct_o,
  output btas_pkg::count_t      sample_total_o,
  output logic                  overflowed_o
);

  btas_pkg::bin_t   mem [btas_pkg::BIN_COUNT];
  btas_pkg::bin_t   rdata_q;
  btas_pkg::bin_t   wdata;
  btas_pkg::score_t raddr;
  btas_pkg::score_t waddr;
  logic             we;

  btas_pkg::score_t code_q;
  btas_pkg::score_t bin_q;
  logic             label_q;
  btas_pkg::count_t acc_total_q;
  btas_pkg::count_t pos_total_q;
  logic             drop_q;

  logic             rd_vld_q;
  btas_pkg::score_t rd_code_q;
  logic             dl_vld_q;
  logic             dl_cand_q;
  btas_pkg::score_t dl_code_q;
  btas_pkg::count_t dl_delta_q;

  btas_pkg::count_t run_q;
  btas_pkg::count_t best_q;
  btas_pkg::score_t best_code_q;
  logic             take;

  btas_pkg::score_t out_thr_q;
  btas_pkg::count_t out_cor_q;
  btas_pkg::count_t out_tot_q;
  logic             out_ovf_q;

  assign raddr = cmd_i.sweep_rd ? code_q : in_score_i;
  assign waddr = cmd_i.samp_write ? bin_q : code_q;
  assign we    = cmd_i.samp_write || cmd_i.wipe || cmd_i.sweep_rd;

  always_comb begin
    wdata = '0;
    if (cmd_i.samp_write) begin
      wdata = rdata_q;
      if (label_q) begin
        wdata.pos = rdata_q.pos + btas_pkg::count_t'(1);
      end else begin
        wdata.neg = rdata_q.neg + btas_pkg::count_t'(1);
      end
    end
  end

  // read returns the old row when the same row is zeroed in the sweep
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q      <= '0;
      acc_total_q <= '0;
      pos_total_q <= '0;
      drop_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      dl_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.wipe || cmd_i.sweep_rd) begin
        code_q <= code_q + btas_pkg::score_t'(1);
      end
      if (cmd_i.cnt_clr) begin
        acc_total_q <= '0;
        pos_total_q <= '0;
        drop_q      <= 1'b0;
      end else begin
        if (cmd_i.samp_write) begin
          acc_total_q <= acc_total_q + btas_pkg::count_t'(1);
          if (label_q) begin
            pos_total_q <= pos_total_q + btas_pkg::count_t'(1);
          end
        end
        if (cmd_i.drop) begin
          drop_q <= 1'b1;
        end
      end
      rd_vld_q <= cmd_i.sweep_rd;
      dl_vld_q <= rd_vld_q;
    end
  end

  assign take = dl_vld_q && dl_cand_q &&
                ((dl_code_q == btas_pkg::score_t'(0)) || (run_q > best_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.samp_start) begin
      bin_q   <= in_score_i;
      label_q <= in_label_i;
    end
    rd_code_q  <= code_q;
    dl_code_q  <= rd_code_q;
    dl_delta_q <= rdata_q.neg - rdata_q.pos;
    dl_cand_q  <= (rd_code_q == btas_pkg::score_t'(0)) || (rd_code_q == '1) ||
                  (rdata_q.neg != '0) || (rdata_q.pos != '0);
    if (cmd_i.sweep_start) begin
      run_q       <= pos_total_q;
      best_q      <= '0;
      best_code_q <= '0;
    end else if (dl_vld_q) begin
      run_q <= run_q + dl_delta_q;
      if (take) begin
        best_q      <= run_q;
        best_code_q <= dl_code_q;
      end
    end
    if (cmd_i.load_out) begin
      out_thr_q <= best_code_q;
      out_cor_q <= best_q;
      out_tot_q <= acc_total_q;
      out_ovf_q <= drop_q;
    end
  end

  assign sts_o.at_cap    = (acc_total_q == '1);
  assign sts_o.code_last = (code_q == '1);
  assign sts_o.pipe_busy = rd_vld_q || dl_vld_q;

  assign best_threshold_o = out_thr_q;
  assign best_correct_o   = out_cor_q;
  assign sample_total_o   = out_tot_q;
  assign overflowed_o     = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_pos_within_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (pos_total_q <= acc_total_q))
    else $error("positive total exceeds sample total");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.cnt_clr |=> (acc_total_q >= $past(acc_total_q)))
    else $error("sample total decreased without clear");

  a_no_update_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dl_vld_q |-> !cmd_i.samp_write && !cmd_i.samp_start)
    else $error("sample update during sweep");
`endif

endmodule

FILE: rtl/best_threshold_accuracy_search_unit.sv
// Sample (add) transaction: one histogram read-modify-write; at the sample
// total cap the sample is dropped instead and flagged as an overflow.
// Clear transaction: totals clear, then one memory row is zeroed per cycle.
// Finish transaction: the sweep reads one row per cycle and zeroes it in the
// same cycle on the write port; the result loads once the output is free.
// Reset: totals clear at once, then a clearing pass runs with in_i.ready low.
// ----------------------------------------------------------------------------
// best_threshold_accuracy_search_unit
// Label histograms of quantized scores; a rising sweep over code 0, the top
// code and occupied codes reports the first with the most correct decisions.
// ----------------------------------------------------------------------------
module best_threshold_accuracy_search_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  btas_in_if.sink      in_i,
  btas_out_if.source   out_o
);

  btas_pkg::ctrl_cmd_t cmd;
  btas_pkg::ctrl_sts_t sts;

  btas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  btas_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_label_i       (in_i.label),
    .in_score_i       (in_i.score),
    .best_threshold_o (out_o.best_threshold),
    .best_correct_o   (out_o.best_correct),
    .sample_total_o   (out_o.sample_total),
    .overflowed_o     (out_o.overflowed)
  );

endmodule
